### sv/ks01_pkg.sv
package ks01_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CAP_W       = 10;
  localparam int WEIGHT_W    = 10;
  localparam int ITEM_VAL_W  = 16;
  localparam int BEST_W      = 26;
  localparam logic [BEST_W-1:0] VALUE_MAX = {BEST_W{1'b1}};

  typedef struct packed {
    logic              load_item;
    logic              rd_en;
    logic              sweep;
    logic              clr_en;
    logic              load_out;
    logic [ADDR_W-1:0] addr;
  } ks01_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cap_eff;
    logic [ADDR_W-1:0] item_w;
    logic              item_fits;
    logic              item_last;
    logic              out_busy;
  } ks01_stat_t;

endpackage

### sv/ks01_ctrl.sv
module ks01_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ks01_pkg::ks01_stat_t stat,
  output ks01_pkg::ks01_cmd_t  cmd
);
  import ks01_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_SWEEP   = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_RESREAD = 3'd4;
  localparam logic [2:0] S_RESLOAD = 3'd5;
  localparam logic [2:0] S_CLEAR   = 3'd6;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] addr, addr_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    addr_next  = addr;
    cmd        = '0;
    cmd.addr   = addr;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.item_fits) begin
          addr_next  = stat.cap_eff;
          state_next = S_SWEEP;
        end else if (stat.item_last) begin
          state_next = S_RESREAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.rd_en = 1'b1;
        cmd.sweep = 1'b1;
        if (addr == stat.item_w) begin
          state_next = S_DRAIN;
        end else begin
          addr_next = addr - 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = stat.item_last ? S_RESREAD : S_IDLE;
      end
      S_RESREAD: begin
        cmd.rd_en  = 1'b1;
        cmd.addr   = stat.cap_eff;
        state_next = S_RESLOAD;
      end
      S_RESLOAD: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          addr_next    = '0;
          state_next   = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      default: begin
        state_next = S_CLEAR;
        addr_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

endmodule

### sv/ks01_dpath.sv
module ks01_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ks01_pkg::CAP_W-1:0]      cfg_wr_data,
  input  logic [ks01_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic [ks01_pkg::ITEM_VAL_W-1:0] in_value,
  input  logic                            in_last,
  input  ks01_pkg::ks01_cmd_t             cmd,
  output ks01_pkg::ks01_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ks01_pkg::BEST_W-1:0]     out_data
);
  import ks01_pkg::*;

  logic [CAP_W-1:0]      capacity;
  logic [ADDR_W-1:0]     cap_now;
  logic [ADDR_W-1:0]     item_cap;
  logic [WEIGHT_W-1:0]   item_weight;
  logic [ITEM_VAL_W-1:0] item_value;
  logic                  item_last;
  logic [BEST_W-1:0]     mem [TABLE_DEPTH];
  logic [BEST_W-1:0]     rd_a, rd_b;
  logic [ADDR_W-1:0]     addr_b;
  logic                  wr_pend;
  logic [ADDR_W-1:0]     wr_addr;
  logic [BEST_W:0]       sum;
  logic [BEST_W-1:0]     cand;

  always_comb begin
    if (int'(capacity) > TABLE_DEPTH - 1) begin
      cap_now = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      cap_now = ADDR_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_weight <= in_weight;
      item_value  <= in_value;
      item_last   <= in_last;
      item_cap    <= cap_now;
    end
  end

  assign stat.cap_eff   = item_cap;
  assign stat.item_w    = ADDR_W'(item_weight);
  assign stat.item_fits = (int'(item_weight) <= int'(item_cap));
  assign stat.item_last = item_last;
  assign stat.out_busy  = out_valid && !out_ready;

  assign addr_b = cmd.addr - ADDR_W'(item_weight);
  assign sum    = {1'b0, rd_b} + (BEST_W + 1)'(item_value);
  assign cand   = (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : sum[BEST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_a <= mem[cmd.addr];
      rd_b <= mem[addr_b];
    end
    if (cmd.clr_en) begin
      mem[cmd.addr] <= '0;
    end else if (wr_pend && (cand > rd_a)) begin
      mem[wr_addr] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= cmd.addr;
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= rd_a;
    end
  end

endmodule

### sv/knapsack_01_max_value_top.sv
// 0/1 knapsack solver. Items stream in on the slave side, one word each:
// weight and value in tdata, tlast marking the final item of a set. The
// capacity register is written through cfg_wr_en/cfg_wr_data, which the
// user must do only while idle; the block itself does not enforce it.
// For each item the table of best values is swept from the capacity down to
// the item weight, one read-modify-write per cycle through a two-read-port
// memory; an item whose weight exceeds the capacity is not swept. On the
// last item of a set, the best value at the capacity is read and, once the
// output register is free, placed in it; then all 1024 table entries are
// cleared, one entry per cycle, before the next word is accepted.
// Reset clears the capacity to zero and the output valid flag, then runs
// the same clearing pass with tready low.
// A result waiting in the output register does not stop new items; only a
// second result stalls (before its clearing pass) until the first is taken.
module knapsack_01_max_value_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ks01_pkg::CAP_W-1:0]    cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: item_weight [9:0], item_value [25:10], zero [31:26]
  input  logic [31:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: best_value [25:0], zero [31:26]
  output logic [31:0]                   m_axis_tdata
);
  import ks01_pkg::*;

  ks01_cmd_t         cmd;
  ks01_stat_t        stat;
  logic [BEST_W-1:0] best_value;

  ks01_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ks01_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_weight   (s_axis_tdata[WEIGHT_W-1:0]),
    .in_value    (s_axis_tdata[WEIGHT_W+ITEM_VAL_W-1:WEIGHT_W]),
    .in_last     (s_axis_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (best_value)
  );

  assign m_axis_tdata = {{(32 - BEST_W){1'b0}}, best_value};

endmodule

### sv/ks01_chk.sv
module ks01_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:26] == 6'd0))
    else $error("output word has bits above the value field");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not held in clearing pass after reset");

endmodule

bind knapsack_01_max_value_top ks01_chk u_ks01_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/knapsack_01_max_value_top_tb.sv
`timescale 1ns / 100ps

module knapsack_01_max_value_top_tb;

  import ks01_pkg::*;

  localparam int SETTLE_CYCLES = 2200;
  localparam int HOLD_CYCLES   = 6000;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int PHASES        = 10;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE
  } ready_mode_e;

  class knapsack_scoreboard;
    logic [BEST_W-1:0] best_at [TABLE_DEPTH];
    logic [CAP_W-1:0]  cap = '0;
    logic [BEST_W-1:0] expected_best [$];
    int errors       = 0;
    int items_seen   = 0;
    int results_seen = 0;

    function void clear_table();
      foreach (best_at[i]) best_at[i] = '0;
    endfunction

    function int pending();
      return expected_best.size();
    endfunction

    function void note_item(logic [WEIGHT_W-1:0] weight, logic [ITEM_VAL_W-1:0] value,
                            logic last_flag);
      logic [BEST_W:0] sum;
      int w;
      int c;
      w = int'(weight);
      items_seen++;
      for (c = int'(cap); c >= w; c--) begin
        sum = {1'b0, best_at[c - w]} + {11'b0, value};
        if (sum > {1'b0, VALUE_MAX}) sum = {1'b0, VALUE_MAX};
        if (sum[BEST_W-1:0] > best_at[c]) best_at[c] = sum[BEST_W-1:0];
      end
      if (last_flag) begin
        expected_best.push_back(best_at[cap]);
        clear_table();
      end
    endfunction

    function void check_result(logic [31:0] word);
      logic [BEST_W-1:0] want;
      results_seen++;
      if (expected_best.size() == 0) begin
        errors++;
        $error("best_value: expected no word, actual %0d", word[BEST_W-1:0]);
        return;
      end
      want = expected_best.pop_front();
      if (word[BEST_W-1:0] !== want) begin
        errors++;
        $error("best_value: expected %0d, actual %0d", want, word[BEST_W-1:0]);
      end
      if (word[31:BEST_W] !== '0) begin
        errors++;
        $error("tdata padding: expected 0, actual %0h", word[31:BEST_W]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  knapsack_scoreboard sb = new;

  ready_mode_e ready_mode   = READY_ALWAYS;
  int          holds_asked  = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b0;
  int          cap_settings = 0;
  int          cycle_count  = 0;

  knapsack_01_max_value_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // The receiver stalls on its own pattern; a requested hold-off overrides it.
  initial begin
    int stall_left;
    int hold_left;
    int holds_granted;
    stall_left    = 0;
    hold_left     = 0;
    holds_granted = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: begin
            m_axis_tready = 1'b1;
          end
          READY_RANDOM: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left    = $urandom_range(0, 12);
              m_axis_tready = 1'b0;
            end else begin
              m_axis_tready = 1'b1;
            end
          end
          default: begin
            if ($urandom_range(0, 1) == 0) begin
              stall_left    = $urandom_range(10, 200);
              m_axis_tready = 1'b0;
            end else begin
              m_axis_tready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic idle_sender(input int cycles);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_item(input logic [WEIGHT_W-1:0] weight,
                           input logic [ITEM_VAL_W-1:0] value, input logic last_flag);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gaps_on) idle_sender($urandom_range(1, 6));
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, value, weight};
    s_axis_tlast  = last_flag;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(weight, value, last_flag);
    @(negedge clk);
  endtask

  // Waits until every result is back and the block has finished any sweep
  // and clearing pass before the capacity register is written.
  task automatic write_capacity(input int value);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = CAP_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.cap    = CAP_W'(value);
    cap_settings++;
  endtask

  task automatic random_items(input int count, input int max_set, input bit close_set);
    int left;
    int pick;
    int wt;
    int val;
    logic last_flag;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) left = $urandom_range(1, max_set);
      left--;
      last_flag = (left == 0) || (close_set && i == count - 1);
      pick = $urandom_range(0, 19);
      if (pick == 0) wt = 0;
      else if (pick < 3) wt = $urandom_range(0, 1023);
      else wt = $urandom_range(0, int'(sb.cap));
      pick = $urandom_range(0, 9);
      if (pick < 6) val = $urandom_range(0, 65535);
      else if (pick < 8) val = $urandom_range(0, 255);
      else if (pick == 8) val = 65535;
      else val = 0;
      send_item(WEIGHT_W'(wt), ITEM_VAL_W'(val), last_flag);
    end
  endtask

  initial begin
    int caps [PHASES];
    int counts [PHASES];
    caps   = '{3, 17, 1, 40, 100, 9, 255, 25, 1023, 60};
    counts = '{50, 50, 30, 50, 40, 50, 35, 50, 15, 50};
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    sb.clear_table();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Zero capacity: zero weight, weights above capacity, a last word that does not fit.
    write_capacity(0);
    send_item(0, 5, 1'b0);
    send_item(1, 65535, 1'b0);
    send_item(1023, 65535, 1'b0);
    send_item(0, 7, 1'b1);
    send_item(5, 9, 1'b1);

    // Full capacity with extreme weights and values.
    write_capacity(1023);
    send_item(1023, 65535, 1'b0);
    send_item(0, 1, 1'b0);
    send_item(1, 40000, 1'b0);
    send_item(512, 30000, 1'b0);
    send_item(511, 20000, 1'b1);
    send_item(1023, 0, 1'b1);
    send_item(0, 65535, 1'b1);

    // Capacity changed in the middle of a set.
    write_capacity(6);
    send_item(2, 10, 1'b0);
    send_item(3, 20, 1'b0);
    write_capacity(3);
    send_item(1, 5, 1'b1);

    // A set of zero-weight items at the largest value, all summed at zero capacity.
    write_capacity(0);
    for (int i = 0; i < 8; i++) send_item(0, 65535, i == 7);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      ready_mode = ready_mode_e'(p % 3);
      gaps_on    = (p % 2 == 0);
      random_items(counts[p], 10, $urandom_range(0, 3) != 0);
    end

    // Long output hold-off while sets keep arriving, so the input backs up.
    write_capacity(5);
    ready_mode = READY_ALWAYS;
    gaps_on    = 1'b0;
    holds_asked++;
    random_items(8, 2, 1'b1);

    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d items and %0d result words over %0d capacity settings,",
             sb.items_seen, sb.results_seen, cap_settings);
    $display("including zero-weight sets, a mid-set capacity change and a long hold-off.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
